/* rtl/core/sicon_pkg.sv */
// Package for the four-dimensional symmetric icon step block.
// Q8.24 types, register indexes and the saturating multiply/add helpers.
// No dependencies.
package sicon_pkg;

  localparam int FRAC_BITS = 24;
  localparam int POWER_STEPS = 6;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t alpha;
    q_t beta;
    q_t gamma;
    q_t lambda;
    q_t omega;
  } coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA  = 3'd0,
    REG_BETA   = 3'd1,
    REG_GAMMA  = 3'd2,
    REG_LAMBDA = 3'd3,
    REG_OMEGA  = 3'd4
  } reg_idx_t;

  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;

  function automatic q_t sat33(input logic signed [32:0] v);
    q_t r;
    if (v > 33'sh07fffffff) r = Q_MAX;
    else if (v < -33'sh080000000) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // Rounds half up and saturates one exact 64-bit product.
  function automatic q_t qround(input logic signed [63:0] p);
    logic signed [64:0] r;
    logic signed [40:0] q;
    q_t o;
    r = {p[63], p} + 65'sd8388608;
    q = r[64:24];
    if (q > 41'sh007fffffff) o = Q_MAX;
    else if (q < -41'sh0080000000) o = Q_MIN;
    else o = q[31:0];
    return o;
  endfunction

endpackage

/* rtl/core/sicon_if.sv */
// Valid/ready channel interfaces for the symmetric icon step block.
// Depends on sicon_pkg.
interface sicon_point_if;
  logic valid;
  logic ready;
  sicon_pkg::q_t a0;
  sicon_pkg::q_t a1;
  sicon_pkg::q_t a2;
  sicon_pkg::q_t a3;
  modport source (output valid, a0, a1, a2, a3, input ready);
  modport sink (input valid, a0, a1, a2, a3, output ready);
endinterface

interface sicon_cfg_if;
  logic valid;
  logic ready;
  logic [63:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/sicon_stage.sv */
// One pipeline stage of a complex pair: state in, state out, under a shared advance.
// Depends on sicon_pkg. OP selects which slice of the pair's work this stage does.
module sicon_stage #(
  parameter int OP = 0
) (
  input  logic               clk,
  input  logic               adv,
  input  sicon_pkg::coef_t   coef,
  input  sicon_pkg::q_t      st_in [8],
  output sicon_pkg::q_t      st_out [8]
);
  // st: 0 a, 1 b, 2 nr, 3 ni, 4 p, 5..7 scratch.
  sicon_pkg::q_t nx [8];
  sicon_pkg::q_t m0, m1, m2, m3;

  always_comb begin
    nx = st_in;
    m0 = '0; m1 = '0; m2 = '0; m3 = '0;
    case (OP)
      0: begin
        // Magnitude products; the power recurrence starts from u itself.
        m0 = sicon_pkg::qround(st_in[0] * st_in[0]);
        m1 = sicon_pkg::qround(st_in[1] * st_in[1]);
        nx[5] = sicon_pkg::qadd(m0, m1);
        nx[2] = st_in[0];
        nx[3] = st_in[1];
      end
      1: begin
        nx[4] = sicon_pkg::qadd(sicon_pkg::qround(coef.alpha * st_in[5]), coef.lambda);
      end
      2: begin
        // One complex multiply by u.
        m0 = sicon_pkg::qround(st_in[2] * st_in[0]);
        m1 = sicon_pkg::qround(st_in[3] * st_in[1]);
        m2 = sicon_pkg::qround(st_in[3] * st_in[0]);
        m3 = sicon_pkg::qround(st_in[2] * st_in[1]);
        nx[2] = sicon_pkg::qsub(m0, m1);
        nx[3] = sicon_pkg::qadd(m2, m3);
      end
      3: begin
        m0 = sicon_pkg::qround(st_in[0] * st_in[2]);
        m1 = sicon_pkg::qround(st_in[1] * st_in[3]);
        nx[5] = sicon_pkg::qsub(m0, m1);
      end
      4: begin
        nx[4] = sicon_pkg::qadd(st_in[4], sicon_pkg::qround(coef.beta * st_in[5]));
      end
      5: begin
        m0 = sicon_pkg::qround(st_in[4] * st_in[0]);
        m1 = sicon_pkg::qround(coef.gamma * st_in[2]);
        m2 = sicon_pkg::qround(st_in[4] * st_in[1]);
        m3 = sicon_pkg::qround(coef.gamma * st_in[3]);
        nx[5] = sicon_pkg::qadd(m0, m1);
        nx[6] = sicon_pkg::qadd(m2, m3);
      end
      default: begin
        m0 = sicon_pkg::qround(coef.omega * st_in[1]);
        m1 = sicon_pkg::qround(coef.omega * st_in[0]);
        nx[2] = sicon_pkg::qsub(st_in[5], m0);
        nx[3] = sicon_pkg::qsub(st_in[6], m1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_out <= nx;
    end
  end
endmodule

/* rtl/core/sicon_lane.sv */
// Full pipeline for one complex pair: a chain of sicon_stage instances.
// Depends on sicon_pkg and sicon_stage.
module sicon_lane (
  input  logic             clk,
  input  logic             adv,
  input  sicon_pkg::coef_t coef,
  input  sicon_pkg::q_t    a,
  input  sicon_pkg::q_t    b,
  output sicon_pkg::q_t    ao,
  output sicon_pkg::q_t    bo
);
  localparam int NST = 6 + sicon_pkg::POWER_STEPS;

  sicon_pkg::q_t st [NST+1][8];

  assign st[0] = '{0: a, 1: b, default: '0};

  for (genvar g = 0; g < NST; g++) begin : g_st
    localparam int OPC = (g < 2) ? g :
                         (g < 2 + sicon_pkg::POWER_STEPS) ? 2 :
                         g - sicon_pkg::POWER_STEPS + 1;
    sicon_stage #(.OP(OPC)) u_stage (
      .clk(clk), .adv(adv), .coef(coef), .st_in(st[g]), .st_out(st[g+1])
    );
  end

  assign ao = st[NST][2];
  assign bo = st[NST][3];
endmodule

/* rtl/core/symmetric_icon_map_4d_step.sv */
// Symmetric icon map step on a 4D point (two complex pairs), Q8.24.
//
// Channels: pt_in carries x,y,z,w as a0..a3; pt_out carries the next
// point the same way; cfg writes the five 64-bit coefficient registers,
// index 0 alpha .. 4 omega, low half for xy and high half for zw.
// Writes to other indexes are dropped. cfg is always ready.
// Pipeline: one stage per step of the pair datapath (magnitude, scale,
// six power steps, Re(u^8), beta term, gamma sums, omega terms).
// Throughput: one beat per cycle. The whole pipeline advances when the
// output register is empty or being taken; a stall freezes every stage,
// so nothing is lost or repeated, and ready falls only then.
// Reset: clears all valid bits and the coefficient registers to zero.
module symmetric_icon_map_4d_step (
  input logic clk,
  input logic rst,
  sicon_point_if.sink   pt_in,
  sicon_point_if.source pt_out,
  sicon_cfg_if.sink     cfg
);
  localparam int NST = 6 + sicon_pkg::POWER_STEPS;

  logic [63:0] alpha_pair, beta_pair, gamma_pair, lambda_pair, omega_pair;
  logic [NST-1:0] vld;
  logic adv;
  sicon_pkg::coef_t c_lo, c_hi;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_pair <= '0; beta_pair <= '0; gamma_pair <= '0;
      lambda_pair <= '0; omega_pair <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == 64'(sicon_pkg::REG_ALPHA)) alpha_pair <= cfg.data;
      if (cfg.index == 64'(sicon_pkg::REG_BETA)) beta_pair <= cfg.data;
      if (cfg.index == 64'(sicon_pkg::REG_GAMMA)) gamma_pair <= cfg.data;
      if (cfg.index == 64'(sicon_pkg::REG_LAMBDA)) lambda_pair <= cfg.data;
      if (cfg.index == 64'(sicon_pkg::REG_OMEGA)) omega_pair <= cfg.data;
    end
  end

  assign c_lo = '{alpha_pair[31:0], beta_pair[31:0], gamma_pair[31:0],
                  lambda_pair[31:0], omega_pair[31:0]};
  assign c_hi = '{alpha_pair[63:32], beta_pair[63:32], gamma_pair[63:32],
                  lambda_pair[63:32], omega_pair[63:32]};

  // The last stage is the output register.
  assign adv = !vld[NST-1] || pt_out.ready;
  assign pt_in.ready = adv;
  assign pt_out.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], pt_in.valid};
    end
  end

  sicon_lane u_xy (
    .clk(clk), .adv(adv), .coef(c_lo), .a(pt_in.a0), .b(pt_in.a1),
    .ao(pt_out.a0), .bo(pt_out.a1)
  );
  sicon_lane u_zw (
    .clk(clk), .adv(adv), .coef(c_hi), .a(pt_in.a2), .b(pt_in.a3),
    .ao(pt_out.a2), .bo(pt_out.a3)
  );
endmodule

/* rtl/core/sicon_checker.sv */
// Port-level assertions for symmetric_icon_map_4d_step, bound to the top level.
// Depends on the channel signals of symmetric_icon_map_4d_step.
module sicon_props (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_a0
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_a0))
    else $error("result changed under stall");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during stall");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind symmetric_icon_map_4d_step sicon_props u_chk (
  .clk(clk), .rst(rst), .in_ready(pt_in.ready),
  .out_valid(pt_out.valid), .out_ready(pt_out.ready), .out_a0(pt_out.a0)
);

/* verif/sicon_checker.sv */
// Checker for the symmetric icon step block: watches the point and config channels,
// predicts each next point in Q8.24 and compares it with what the block returns.
// Depends on sicon_pkg and sicon_if.
module sicon_checker (
  input  logic            clk,
  input  logic            rst,
  sicon_point_if.sink     pt_in,
  sicon_point_if.sink     pt_out,
  sicon_cfg_if.sink       cfg,
  output int              fail_count,
  output int              pending_points,
  output int              points_checked
);
  typedef struct packed {
    sicon_pkg::q_t x;
    sicon_pkg::q_t y;
    sicon_pkg::q_t z;
    sicon_pkg::q_t w;
  } point_t;

  logic [63:0] alpha_r, beta_r, gamma_r, lambda_r, omega_r;
  point_t next_points[$];

  function automatic sicon_pkg::q_t fx_sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic sicon_pkg::q_t fx_mul(input sicon_pkg::q_t a, input sicon_pkg::q_t b);
    logic signed [65:0] p;
    p = (66'(a) * 66'(b) + 66'sd8388608) >>> 24;
    return fx_sat(p);
  endfunction

  function automatic sicon_pkg::q_t fx_add(input sicon_pkg::q_t a, input sicon_pkg::q_t b);
    return fx_sat(66'(a) + 66'(b));
  endfunction

  function automatic sicon_pkg::q_t fx_sub(input sicon_pkg::q_t a, input sicon_pkg::q_t b);
    return fx_sat(66'(a) - 66'(b));
  endfunction

  task automatic icon_pair_next(input sicon_pkg::q_t a, input sicon_pkg::q_t b, input int sh,
                                output sicon_pkg::q_t ao, output sicon_pkg::q_t bo);
    sicon_pkg::q_t al, be, ga, la, om, mag, p, nr, ni, tr, ti;
    al = alpha_r[sh +: 32];
    be = beta_r[sh +: 32];
    ga = gamma_r[sh +: 32];
    la = lambda_r[sh +: 32];
    om = omega_r[sh +: 32];
    mag = fx_add(fx_mul(a, a), fx_mul(b, b));
    p = fx_add(fx_mul(al, mag), la);
    nr = a;
    ni = b;
    for (int i = 0; i < 6; i++) begin
      tr = fx_sub(fx_mul(nr, a), fx_mul(ni, b));
      ti = fx_add(fx_mul(ni, a), fx_mul(nr, b));
      nr = tr;
      ni = ti;
    end
    p = fx_add(p, fx_mul(be, fx_sub(fx_mul(a, nr), fx_mul(b, ni))));
    ao = fx_sub(fx_add(fx_mul(p, a), fx_mul(ga, nr)), fx_mul(om, b));
    bo = fx_sub(fx_add(fx_mul(p, b), fx_mul(ga, ni)), fx_mul(om, a));
  endtask

  assign pending_points = next_points.size();

  always @(posedge clk) begin
    point_t e;
    point_t got;
    if (rst) begin
      alpha_r <= '0; beta_r <= '0; gamma_r <= '0; lambda_r <= '0; omega_r <= '0;
      next_points.delete();
      fail_count <= 0;
      points_checked <= 0;
    end else begin
      // Outputs are checked first: a beat accepted this edge cannot emerge yet.
      if (pt_out.valid && pt_out.ready) begin
        got = {pt_out.a0, pt_out.a1, pt_out.a2, pt_out.a3};
        points_checked <= points_checked + 1;
        if (next_points.size() == 0) begin
          if (fail_count < 10) $display("unexpected output beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          e = next_points.pop_front();
          if (e !== got) begin
            if (fail_count < 10)
              $display("mismatch: expected x=%h y=%h z=%h w=%h got x=%h y=%h z=%h w=%h",
                       e.x, e.y, e.z, e.w, got.x, got.y, got.z, got.w);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (pt_in.valid && pt_in.ready) begin
        icon_pair_next(pt_in.a0, pt_in.a1, 0, e.x, e.y);
        icon_pair_next(pt_in.a2, pt_in.a3, 32, e.z, e.w);
        next_points.push_back(e);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          64'(sicon_pkg::REG_ALPHA):  alpha_r  <= cfg.data;
          64'(sicon_pkg::REG_BETA):   beta_r   <= cfg.data;
          64'(sicon_pkg::REG_GAMMA):  gamma_r  <= cfg.data;
          64'(sicon_pkg::REG_LAMBDA): lambda_r <= cfg.data;
          64'(sicon_pkg::REG_OMEGA):  omega_r  <= cfg.data;
          default: ;
        endcase
      end
    end
  end
endmodule

/* verif/tb_top.sv */
// Top of the symmetric icon step testbench: clock, reset, stimulus and verdict.
// Depends on sicon_pkg, sicon_if, sicon_checker and the block itself.
module tb_top;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_points, points_checked;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  bit   hold_sink = 1'b0;
  int   points_sent = 0;

  sicon_point_if pt_in();
  sicon_point_if pt_out();
  sicon_cfg_if   cfg();

  symmetric_icon_map_4d_step i_dut (
    .clk(clk), .rst(rst), .pt_in(pt_in.sink), .pt_out(pt_out.source), .cfg(cfg.sink)
  );

  sicon_checker i_checker (
    .clk(clk), .rst(rst), .pt_in(pt_in.sink), .pt_out(pt_out.sink), .cfg(cfg.sink),
    .fail_count(fail_count), .pending_points(pending_points),
    .points_checked(points_checked)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a held-off stretch on request.
  always @(posedge clk) begin
    if (rst) pt_out.ready <= 1'b0;
    else pt_out.ready <= !hold_sink && ($urandom_range(99) >= out_stall_pct);
  end

  // Valid stays high after an accepted beat so that beats can follow back to back;
  // it drops only for an idle cycle or when the sender waits for the results.
  task automatic send_point(input sicon_pkg::q_t x, input sicon_pkg::q_t y,
                            input sicon_pkg::q_t z, input sicon_pkg::q_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      pt_in.valid <= 1'b0;
      @(posedge clk);
    end
    pt_in.valid <= 1'b1;
    pt_in.a0 <= x; pt_in.a1 <= y; pt_in.a2 <= z; pt_in.a3 <= w;
    @(posedge clk);
    while (!pt_in.ready) @(posedge clk);
    points_sent++;
  endtask

  task automatic drain_points();
    pt_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_coef(input sicon_pkg::reg_idx_t idx, input logic [63:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= 64'(idx);
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Small coefficients keep the map near its attractor; a share are fully random and a share are the extremes.
  function automatic logic [31:0] pick_coef();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(8388608)) - 32'sd4194304) <<< 4;
      2: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(33554432)) - 32'sd16777216);
    endcase
  endfunction

  function automatic sicon_pkg::q_t pick_coord();
    case ($urandom_range(3))
      0: return $urandom();
      default: return 32'($signed($urandom_range(50331648)) - 32'sd25165824);
    endcase
  endfunction

  task automatic load_random_coefs();
    write_coef(sicon_pkg::REG_ALPHA,  {pick_coef(), pick_coef()});
    write_coef(sicon_pkg::REG_BETA,   {pick_coef(), pick_coef()});
    write_coef(sicon_pkg::REG_GAMMA,  {pick_coef(), pick_coef()});
    write_coef(sicon_pkg::REG_LAMBDA, {pick_coef(), pick_coef()});
    write_coef(sicon_pkg::REG_OMEGA,  {pick_coef(), pick_coef()});
  endtask

  initial begin
    sicon_pkg::q_t ext[6];
    sicon_pkg::q_t px, py, pz, pw;
    pt_in.valid = 1'b0;
    pt_in.a0 = '0; pt_in.a1 = '0; pt_in.a2 = '0; pt_in.a3 = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh01000000, 32'shff000000,
            32'sh00000001};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset coefficients, then extremes and the classic icon set.
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    drain_points();
    write_coef(sicon_pkg::REG_ALPHA,  64'hffffffff_80000000);
    write_coef(sicon_pkg::REG_BETA,   64'h7fffffff_80000000);
    write_coef(sicon_pkg::REG_GAMMA,  64'h80000000_7fffffff);
    write_coef(sicon_pkg::REG_LAMBDA, 64'h7fffffff_7fffffff);
    write_coef(sicon_pkg::REG_OMEGA,  64'h80000000_80000000);
    write_coef(sicon_pkg::reg_idx_t'(3'd7), 64'hdeadbeef_deadbeef);
    for (int i = 0; i < 6; i++)
      send_point(ext[i], ext[5-i], ext[(i+2)%6], ext[(i+4)%6]);
    drain_points();
    write_coef(sicon_pkg::REG_ALPHA,  64'hfd800000_fd800000);
    write_coef(sicon_pkg::REG_BETA,   64'hffe66666_ffe66666);
    write_coef(sicon_pkg::REG_GAMMA,  64'h00199999_00199999);
    write_coef(sicon_pkg::REG_LAMBDA, 64'h02800000_02800000);
    write_coef(sicon_pkg::REG_OMEGA,  64'h00000000_00333333);
    for (int i = 0; i < 12; i++)
      send_point(ext[i%6], ext[(i/2)%6], 32'sh00400000, 32'shffc00000);

    // Random phases with different idling mixes; each point is picked at random.
    for (int ph = 0; ph < 8; ph++) begin
      drain_points();
      load_random_coefs();
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 67; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 67; end
        default: begin in_idle_pct = 35; out_stall_pct = 35; end
      endcase
      px = pick_coord(); py = pick_coord(); pz = pick_coord(); pw = pick_coord();
      for (int k = 0; k < 85; k++) begin
        if (ph == 2 && k == 10) begin
          // Long hold-off on the receiver while points keep coming.
          fork
            begin
              hold_sink = 1'b1;
              repeat (60) @(posedge clk);
              hold_sink = 1'b0;
            end
          join_none
        end
        if (ph == 5 && k == 40) drain_points();
        send_point(px, py, pz, pw);
        px = pick_coord(); py = pick_coord(); pz = pick_coord(); pw = pick_coord();
      end
    end

    drain_points();
    $display("Run covered %0d points over the reset, two directed and eight random",
             points_sent);
    $display("coefficient sets, with idling and stalls; outputs checked: %0d.",
             points_checked);
    if (fail_count == 0 && pending_points == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
